/* rtl/core/ohtbl_pkg.sv */
`timescale 1ns / 1ps

package ohtbl_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VAL_W       = 32;

	typedef enum logic [2:0] {
		OP_ADD_ID     = 3'd0,
		OP_ADD_OBJ    = 3'd1,
		OP_REMOVE     = 3'd2,
		OP_LOOKUP_ID  = 3'd3,
		OP_LOOKUP_OBJ = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MATCH = 2'd1,
		ST_APPLY = 2'd2
	} state_t;

	// control word broadcast from the sequencer to every cell
	typedef struct packed {
		logic             match_en;  // capture first-hit flag
		logic             use_obj;   // compare handles instead of ids
		logic             update;    // first-hit cell takes a new handle
		logic             shift;     // cells at/after the hit pull from the right
		logic             append;    // cell at index == count is written
		logic [CNT_W-1:0] count;     // live entries
		logic [VAL_W-1:0] key_id;
		logic [VAL_W-1:0] key_obj;   // also the handle written on update/append
		logic [VAL_W-1:0] wr_id;     // id written on append
	} cell_ctl_t;

endpackage

/* rtl/core/id_object_handle_table_top.sv */
`timescale 1ns / 1ps

// Channel  Dir  Words          Contents
// s_*      in   op + id + obj  tuser[2:0] op; tdata[31:0] id_in, tdata[63:32] object_in
// m_*      out  one per input  tuser[0] found, tuser[1] status; tdata id_out, object_out
//
// Each word goes through accept, match (all cells compare at once, first hit
// found by a ripple through the cell row) and apply (update, shift or append).
// One word is in flight at a time; s_tready is high only while idle.
// The result sits in an output register; a stalled m_tready holds the apply
// step, so a new word may be accepted while a result waits.
// arst_n clears the sequencer, entry count and running id; cell contents are
// left as they are and only entries below the count are ever looked at.
module id_object_handle_table_top import ohtbl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] id_in, [63:32] object_in
	input  logic [2:0]  s_tuser,   // [2:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] id_out, [63:32] object_out
	output logic [1:0]  m_tuser    // [0] found, [1] status
);

	state_t state_q, state_nxt;

	logic [2:0]       op_q;
	logic [VAL_W-1:0] key_id_q;
	logic [VAL_W-1:0] key_obj_q;
	logic             found_q;
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] running_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_id_q;
	logic [VAL_W-1:0] out_obj_q;
	logic             out_found_q;
	logic             out_status_q;

	logic             in_fire;
	logic             match_en;
	logic             apply_fire;
	cell_ctl_t        ctl;

	// row wiring
	logic             prior   [TABLE_DEPTH+1];
	logic             after   [TABLE_DEPTH+1];
	logic [VAL_W-1:0] sel     [TABLE_DEPTH+1];
	logic [VAL_W-1:0] id_row  [TABLE_DEPTH];
	logic [VAL_W-1:0] obj_row [TABLE_DEPTH];

	// apply-step decisions
	logic             full;
	logic             hit;
	logic [VAL_W-1:0] run_inc;
	logic             r_found, r_status, r_update, r_shift, r_append;
	logic [VAL_W-1:0] r_id, r_obj, r_wr_id, r_run;
	logic [CNT_W-1:0] r_count;

	// ---------------- sequencer ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_nxt = ST_MATCH;
			ST_MATCH: state_nxt = ST_APPLY;
			ST_APPLY: if (!out_valid_q || m_tready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		match_en   = 1'b0;
		apply_fire = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready   = 1'b1;
			ST_MATCH: match_en   = 1'b1;
			ST_APPLY: apply_fire = !out_valid_q || m_tready;
			default:  s_tready   = 1'b0;
		endcase
	end

	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q      <= s_tuser;
			key_id_q  <= s_tdata[31:0];
			key_obj_q <= s_tdata[63:32];
		end
		if (match_en) begin
			found_q <= prior[TABLE_DEPTH];
		end
	end

	// ---------------- apply step ----------------
	assign full    = count_q == CNT_W'(TABLE_DEPTH);
	assign hit     = found_q;
	assign run_inc = running_q + VAL_W'(1);

	always_comb begin
		r_found  = 1'b0;
		r_status = 1'b0;
		r_update = 1'b0;
		r_shift  = 1'b0;
		r_append = 1'b0;
		r_id     = '0;
		r_obj    = '0;
		r_wr_id  = key_id_q;
		r_run    = running_q;
		r_count  = count_q;
		case (op_q)
			OP_ADD_ID: begin
				if (key_id_q > running_q) r_run = key_id_q;
				if (hit) begin
					r_found  = 1'b1;
					r_update = 1'b1;
				end else if (full) begin
					r_status = 1'b1;
				end else begin
					r_append = 1'b1;
					r_count  = count_q + CNT_W'(1);
				end
			end
			OP_ADD_OBJ: begin
				// on add, a null handle never matches an existing entry
				if (hit && key_obj_q != '0) begin
					r_found = 1'b1;
					r_id    = sel[TABLE_DEPTH];
				end else if (full) begin
					r_status = 1'b1;
				end else begin
					r_run    = run_inc;
					r_id     = run_inc;
					r_wr_id  = run_inc;
					r_append = 1'b1;
					r_count  = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					r_found = 1'b1;
					r_shift = 1'b1;
					r_count = count_q - CNT_W'(1);
				end
			end
			OP_LOOKUP_ID: begin
				r_found = hit;
				r_obj   = sel[TABLE_DEPTH];
			end
			OP_LOOKUP_OBJ: begin
				r_found = hit;
				r_id    = sel[TABLE_DEPTH];
			end
			default: r_found = 1'b0;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.match_en = match_en;
		ctl.use_obj  = (op_q == OP_ADD_OBJ) || (op_q == OP_LOOKUP_OBJ);
		ctl.update   = apply_fire && r_update;
		ctl.shift    = apply_fire && r_shift;
		ctl.append   = apply_fire && r_append;
		ctl.count    = count_q;
		ctl.key_id   = key_id_q;
		ctl.key_obj  = key_obj_q;
		ctl.wr_id    = r_wr_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply_fire) begin
				count_q   <= r_count;
				running_q <= r_run;
			end
			if (apply_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			out_id_q     <= r_id;
			out_obj_q    <= r_obj;
			out_found_q  <= r_found;
			out_status_q <= r_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_obj_q, out_id_q};
	assign m_tuser  = {out_status_q, out_found_q};

	// ---------------- cell row ----------------
	assign prior[0] = 1'b0;
	assign after[0] = 1'b0;
	assign sel[0]   = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] nid, nobj;
		if (i == TABLE_DEPTH - 1) begin : g_end
			// last cell shifts onto itself; it falls out of the count anyway
			assign nid  = id_row[i];
			assign nobj = obj_row[i];
		end else begin : g_mid
			assign nid  = id_row[i+1];
			assign nobj = obj_row[i+1];
		end

		ohtbl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.idx       (IDX_W'(i)),
			.nxt_id    (nid),
			.nxt_obj   (nobj),
			.prior_in  (prior[i]),
			.prior_out (prior[i+1]),
			.after_in  (after[i]),
			.after_out (after[i+1]),
			.sel_in    (sel[i]),
			.sel_out   (sel[i+1]),
			.id_val    (id_row[i]),
			.obj_val   (obj_row[i])
		);
	end

endmodule

/* rtl/core/ohtbl_cell.sv */
`timescale 1ns / 1ps

module ohtbl_cell import ohtbl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic [VAL_W-1:0] nxt_id,
	input  logic [VAL_W-1:0] nxt_obj,
	input  logic             prior_in,
	output logic             prior_out,
	input  logic             after_in,
	output logic             after_out,
	input  logic [VAL_W-1:0] sel_in,
	output logic [VAL_W-1:0] sel_out,
	output logic [VAL_W-1:0] id_val,
	output logic [VAL_W-1:0] obj_val
);

	logic [VAL_W-1:0] id_q;
	logic [VAL_W-1:0] obj_q;
	logic             first_q;
	logic             live;
	logic             hit;
	logic             sh;
	logic [CNT_W-1:0] pos;

	assign pos       = CNT_W'(idx);
	assign live      = pos < ctl.count;
	assign hit       = live && (ctl.use_obj ? (obj_q == ctl.key_obj) : (id_q == ctl.key_id));
	assign prior_out = prior_in | hit;

	// at or after the first hit: these cells shift on remove
	assign sh        = after_in | first_q;
	assign after_out = sh;

	// returned value: id when searching by handle, handle when searching by id
	assign sel_out = sel_in | ({VAL_W{first_q}} & (ctl.use_obj ? id_q : obj_q));
	assign id_val  = id_q;
	assign obj_val = obj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (ctl.match_en) begin
			first_q <= hit & ~prior_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.append && pos == ctl.count) begin
			id_q  <= ctl.wr_id;
			obj_q <= ctl.key_obj;
		end else if (ctl.shift && sh) begin
			id_q  <= nxt_id;
			obj_q <= nxt_obj;
		end else if (ctl.update && first_q) begin
			obj_q <= ctl.key_obj;
		end
	end

endmodule

/* rtl/core/ohtbl_checker.sv */
`timescale 1ns / 1ps

module ohtbl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// one word in flight: no accept during the match and apply steps after one
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
		else $error("input accepted while a word is in flight");

	// a hit never also reports a dropped append
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("found and status both set");

	// at most one of id_out / object_out carries a value
	a_one_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:0] == 32'd0 || m_tdata[63:32] == 32'd0))
		else $error("both id_out and object_out nonzero");

	// a dropped append returns no value
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == 64'd0))
		else $error("dropped append returned data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result word changed");

endmodule

bind id_object_handle_table_top ohtbl_checker u_ohtbl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
